// ===== rtl/core/pcc_pkg.sv =====
// ============================================================================
// pcc_pkg : shared types and constants of the polar/cartesian converter
// Word widths of the rotation chain, the arctangent table, the gain
// correction constant and the structs passed between stages.
// ============================================================================
`default_nettype none

package pcc_pkg;

    // coordinate and chain configuration
    localparam int COORD_WIDTH    = 16;
    localparam int ROTATION_STEPS = 16;
    localparam int GUARD_BITS     = 24;
    localparam int TABLE_LEN      = 24;
    localparam int STEP_W         = $clog2(TABLE_LEN);

    // port field widths
    localparam int FIELD_W = 16;
    localparam int CART_W  = 17;

    // rotation word: sign, growth headroom, coordinate bits, fraction bits
    localparam int DATA_W = COORD_WIDTH + GUARD_BITS + 3;
    // angle accumulator, units of 2^-32 turn plus headroom
    localparam int ACC_W  = 34;
    localparam int TURN_W = 32;

    // gain correction: 1/K in Q31
    localparam int            INV_W        = 31;
    localparam logic [30:0]   INV_GAIN_Q31 = 31'd1304065748;

    // scaling stage widths
    localparam int MAG_W   = DATA_W - 1;
    localparam int HI_W    = MAG_W - 32;
    localparam int LO_W    = 32 + INV_W;
    localparam int SUM_A_W = HI_W + 32;
    localparam int SUM_B_W = GUARD_BITS + FIELD_W + 1;
    localparam int SUM_W   = (SUM_A_W > SUM_B_W) ? SUM_A_W : SUM_B_W;
    localparam int M_W     = SUM_W - (GUARD_BITS - 1);

    // command codes
    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_CART  = 1'b1;

    // fixed angles of the axis points
    localparam logic [15:0] ANGLE_ZERO    = 16'd0;
    localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
    localparam logic [15:0] ANGLE_HALF    = 16'd32768;
    localparam logic [15:0] ANGLE_3QUART  = 16'd49152;

    // word carried along the rotation chain
    typedef struct packed {
        logic                cart;
        logic                byp;
        logic [FIELD_W-1:0]  byp_rad;
        logic [FIELD_W-1:0]  byp_ang;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic [ACC_W-1:0]    z;
    } rot_t;

    // one finished result
    typedef struct packed {
        logic [FIELD_W-1:0] radius;
        logic [FIELD_W-1:0] angle;
        logic [CART_W-1:0]  x;
        logic [CART_W-1:0]  y;
    } res_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TURN_W-1:0] arc_of(input logic [STEP_W-1:0] step);
        logic [TURN_W-1:0] arc;
        unique case (step)
            5'd0:    arc = 32'h20000000;
            5'd1:    arc = 32'h12E4051E;
            5'd2:    arc = 32'h09FB385B;
            5'd3:    arc = 32'h051111D4;
            5'd4:    arc = 32'h028B0D43;
            5'd5:    arc = 32'h0145D7E1;
            5'd6:    arc = 32'h00A2F61E;
            5'd7:    arc = 32'h00517C55;
            5'd8:    arc = 32'h0028BE53;
            5'd9:    arc = 32'h00145F2F;
            5'd10:   arc = 32'h000A2F98;
            5'd11:   arc = 32'h000517CC;
            5'd12:   arc = 32'h00028BE6;
            5'd13:   arc = 32'h000145F3;
            5'd14:   arc = 32'h0000A2FA;
            5'd15:   arc = 32'h0000517D;
            5'd16:   arc = 32'h000028BE;
            5'd17:   arc = 32'h0000145F;
            5'd18:   arc = 32'h00000A30;
            5'd19:   arc = 32'h00000518;
            5'd20:   arc = 32'h0000028C;
            5'd21:   arc = 32'h00000146;
            5'd22:   arc = 32'h000000A3;
            5'd23:   arc = 32'h00000051;
            default: arc = 32'h00000000;
        endcase
        return arc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/polar_cartesian_converter.sv =====
// ============================================================================
// polar_cartesian_converter : CORDIC polar/cartesian conversion
// Command 0 turns a point into magnitude and angle, command 1 turns a
// radius and angle into x and y, through a chain of rotation cells.
// ============================================================================
// Takes one item every clock while item_stall is low and delivers one result
// per item, in order. A result passes through one input stage, one cell per
// micro-rotation, four stages of gain correction and formatting, and the
// output register. The chain of rotation cells sets the latency; a skid
// register behind the output lets the chain keep running when result_stall
// rises, until a result lands in the skid register, after which item_stall
// holds new items until the skid register drains.
`default_nettype none

module polar_cartesian_converter
    import pcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                command,
    input  wire logic [FIELD_W-1:0]  x_in,
    input  wire logic [FIELD_W-1:0]  y_in,
    input  wire logic [FIELD_W-1:0]  radius_in,
    input  wire logic [FIELD_W-1:0]  angle_in,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [FIELD_W-1:0]       radius_out,
    output logic [FIELD_W-1:0]       angle_out,
    output logic [CART_W-1:0]        x_out,
    output logic [CART_W-1:0]        y_out
);

    logic   en;
    logic   load;
    logic   chain_valid [ROTATION_STEPS+1];
    rot_t   chain_word  [ROTATION_STEPS+1];
    logic   tail_valid;
    res_t   tail_res;

    logic   out_valid_reg;
    logic   out_valid_next;
    res_t   out_res_reg;
    res_t   out_res_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    res_t   skid_res_reg;
    res_t   skid_res_next;
    logic   out_free;

    // whole chain moves unless the skid register is holding a result
    assign en         = !skid_valid_reg;
    assign item_stall = skid_valid_reg;
    assign load       = item_valid && !item_stall;

    pcc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .load      (load),
        .command   (command),
        .x_in      (x_in),
        .y_in      (y_in),
        .radius_in (radius_in),
        .angle_in  (angle_in),
        .valid     (chain_valid[0]),
        .word      (chain_word[0])
    );

    // rotation cells
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_cell
        pcc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    pcc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[ROTATION_STEPS]),
        .in_word   (chain_word[ROTATION_STEPS]),
        .out_valid (tail_valid),
        .out_res   (tail_res)
    );

    // output register with skid stage
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_next = tail_valid;
            out_res_next   = tail_res;
        end
        else if (tail_valid)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = tail_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign result_valid = out_valid_reg;
    assign radius_out   = out_res_reg.radius;
    assign angle_out    = out_res_reg.angle;
    assign x_out        = out_res_reg.x;
    assign y_out        = out_res_reg.y;

    // skid register is only used behind a waiting output
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with output register empty");

    // skid register fills only when the output was held
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid register filled without a held output");

    // a taken result with nothing behind it leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_stall && !skid_valid_reg && !tail_valid)
        |=> !out_valid_reg)
        else $error("output stayed valid with no result behind it");

endmodule

`default_nettype wire

// ===== rtl/core/pcc_prep.sv =====
// ============================================================================
// pcc_prep : input stage of the converter
// Sorts out the axis points, folds the left half plane or the back half
// of the circle and loads the first rotation word.
// ============================================================================
`default_nettype none

module pcc_prep
    import pcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                load,
    input  wire logic                command,
    input  wire logic [FIELD_W-1:0]  x_in,
    input  wire logic [FIELD_W-1:0]  y_in,
    input  wire logic [FIELD_W-1:0]  radius_in,
    input  wire logic [FIELD_W-1:0]  angle_in,
    output logic                     valid,
    output rot_t                     word
);

    logic               valid_reg;
    rot_t               word_reg;
    rot_t               word_next;

    logic [COORD_WIDTH:0] xs;
    logic [COORD_WIDTH:0] ys;
    logic [COORD_WIDTH:0] x_abs;
    logic [COORD_WIDTH:0] y_abs;
    logic [COORD_WIDTH:0] xf;
    logic [COORD_WIDTH:0] yf;
    logic                 x_zero;
    logic                 y_zero;
    logic [DATA_W-1:0]    r_word;
    logic                 fold;
    logic [TURN_W-1:0]    z_cart;

    // sign-extended coordinates, their magnitudes and the point folded into the right half plane
    assign xs    = {x_in[COORD_WIDTH-1], x_in[COORD_WIDTH-1:0]};
    assign ys    = {y_in[COORD_WIDTH-1], y_in[COORD_WIDTH-1:0]};
    assign x_abs = xs[COORD_WIDTH] ? -xs : xs;
    assign y_abs = ys[COORD_WIDTH] ? -ys : ys;
    assign xf    = xs[COORD_WIDTH] ? -xs : xs;
    assign yf    = xs[COORD_WIDTH] ? -ys : ys;
    assign x_zero = (xs == '0);
    assign y_zero = (ys == '0);

    // polar side: angles in the second and third quarter turn are folded
    assign r_word = {3'b000, radius_in[COORD_WIDTH-1:0], {GUARD_BITS{1'b0}}};
    assign fold   = angle_in[15] ^ angle_in[14];
    assign z_cart = {~angle_in[15], angle_in[14:0], 16'h0000} ^
                    {~fold, {(TURN_W-1){1'b0}}};

    // first rotation word
    always_comb
    begin
        word_next         = '0;
        word_next.cart    = command;
        word_next.byp_rad = '0;
        word_next.byp_ang = ANGLE_ZERO;
        if (command == CMD_TO_CART)
        begin
            word_next.a = fold ? -r_word : r_word;
            word_next.b = '0;
            word_next.z = {{(ACC_W-TURN_W){z_cart[TURN_W-1]}}, z_cart};
        end
        else
        begin
            word_next.a = {{2{xf[COORD_WIDTH]}}, xf, {GUARD_BITS{1'b0}}};
            word_next.b = {{2{yf[COORD_WIDTH]}}, yf, {GUARD_BITS{1'b0}}};
            word_next.z = xs[COORD_WIDTH] ? {{(ACC_W-TURN_W){1'b0}}, 1'b1,
                                             {(TURN_W-1){1'b0}}} : '0;
            priority if (x_zero && y_zero)
            begin
                word_next.byp = 1'b1;
            end
            else if (y_zero)
            begin
                word_next.byp     = 1'b1;
                word_next.byp_rad = FIELD_W'(x_abs);
                word_next.byp_ang = xs[COORD_WIDTH] ? ANGLE_HALF : ANGLE_ZERO;
            end
            else if (x_zero)
            begin
                word_next.byp     = 1'b1;
                word_next.byp_rad = FIELD_W'(y_abs);
                word_next.byp_ang = ys[COORD_WIDTH] ? ANGLE_3QUART : ANGLE_QUARTER;
            end
            else
            begin
                word_next.byp = 1'b0;
            end
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= load;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en && load)
            word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcc_cell.sv =====
// ============================================================================
// pcc_cell : one micro-rotation of the chain
// Shifts both coordinates by its step number, turns the vector one way or
// the other and updates the angle accumulator with the matching arctangent.
// ============================================================================
`default_nettype none

module pcc_cell
    import pcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [STEP_W-1:0]  step,
    input  wire logic               in_valid,
    input  wire rot_t               in_word,
    output logic                    out_valid,
    output rot_t                    out_word
);

    logic               valid_reg;
    rot_t               word_reg;
    rot_t               word_next;
    logic [DATA_W-1:0]  sa;
    logic [DATA_W-1:0]  sb;
    logic [ACC_W-1:0]   arc;
    logic               b_pos;
    logic               turn_back;

    // shifted terms and arctangent of this step
    assign sa  = DATA_W'($signed(in_word.a) >>> step);
    assign sb  = DATA_W'($signed(in_word.b) >>> step);
    assign arc = {{(ACC_W-TURN_W){1'b0}}, arc_of(step)};

    // vectoring drives b to zero, rotation drives the residual angle to zero
    assign b_pos     = !in_word.b[DATA_W-1] && (in_word.b != '0);
    assign turn_back = in_word.cart ? in_word.z[ACC_W-1] : b_pos;

    always_comb
    begin
        word_next = in_word;
        if (turn_back)
        begin
            word_next.a = in_word.a + sb;
            word_next.b = in_word.b - sa;
            word_next.z = in_word.z + arc;
        end
        else
        begin
            word_next.a = in_word.a - sb;
            word_next.b = in_word.b + sa;
            word_next.z = in_word.z - arc;
        end
    end

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcc_post.sv =====
// ============================================================================
// pcc_post : gain correction and result formatting
// Four stages: magnitudes and angle rounding, split multiply by 1/K,
// sum and rounding, then saturation, signs and result selection.
// ============================================================================
`default_nettype none

module pcc_post
    import pcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire rot_t  in_word,
    output logic       out_valid,
    output res_t       out_res
);

    // per-stage control
    typedef struct packed {
        logic               cart;
        logic               byp;
        logic [FIELD_W-1:0] byp_rad;
        logic [FIELD_W-1:0] byp_ang;
        logic [FIELD_W-1:0] ang;
        logic               neg_a;
        logic               neg_b;
    } side_t;

    logic [3:0]             valid_reg;

    side_t                  s1_reg;
    side_t                  s2_reg;
    side_t                  s3_reg;
    side_t                  s1_next;

    logic [MAG_W-1:0]       mag_a_reg;
    logic [MAG_W-1:0]       mag_b_reg;
    logic [MAG_W-1:0]       mag_a_next;
    logic [MAG_W-1:0]       mag_b_next;
    logic [DATA_W-1:0]      abs_a;
    logic [DATA_W-1:0]      abs_b;
    logic [TURN_W-1:0]      ang_sum;

    logic [HI_W+INV_W-1:0]  hi_a_reg;
    logic [HI_W+INV_W-1:0]  hi_b_reg;
    logic [INV_W-1:0]       lo_a_reg;
    logic [INV_W-1:0]       lo_b_reg;
    logic [LO_W-1:0]        lo_a_prod;
    logic [LO_W-1:0]        lo_b_prod;

    logic [SUM_W-1:0]       sum_a;
    logic [SUM_W-1:0]       sum_b;
    logic [M_W-1:0]         m_a_reg;
    logic [M_W-1:0]         m_b_reg;

    logic [FIELD_W-1:0]     sat_a;
    logic [FIELD_W-1:0]     sat_b;
    res_t                   res_reg;
    res_t                   res_next;

    // stage 1: magnitudes, sign flags and rounded angle
    assign abs_a   = in_word.a[DATA_W-1] ? -in_word.a : in_word.a;
    assign abs_b   = in_word.b[DATA_W-1] ? -in_word.b : in_word.b;
    assign ang_sum = in_word.z[TURN_W-1:0] + TURN_W'(32'h8000);

    always_comb
    begin
        s1_next.cart    = in_word.cart;
        s1_next.byp     = in_word.byp;
        s1_next.byp_rad = in_word.byp_rad;
        s1_next.byp_ang = in_word.byp_ang;
        s1_next.ang     = ang_sum[TURN_W-1:TURN_W-FIELD_W];
        s1_next.neg_a   = in_word.cart & in_word.a[DATA_W-1];
        s1_next.neg_b   = in_word.b[DATA_W-1];
        mag_b_next      = abs_b[MAG_W-1:0];
        if (!in_word.cart && in_word.a[DATA_W-1])
            mag_a_next = '0;
        else
            mag_a_next = abs_a[MAG_W-1:0];
    end

    // stage 2: low products, upper half only kept
    assign lo_a_prod = LO_W'(mag_a_reg[31:0]) * LO_W'(INV_GAIN_Q31);
    assign lo_b_prod = LO_W'(mag_b_reg[31:0]) * LO_W'(INV_GAIN_Q31);

    // stage 3: sum of partial products and rounding
    assign sum_a = SUM_W'(hi_a_reg) + SUM_W'(lo_a_reg) +
                   SUM_W'(1) * (SUM_W'(1) << (GUARD_BITS - 2));
    assign sum_b = SUM_W'(hi_b_reg) + SUM_W'(lo_b_reg) +
                   SUM_W'(1) * (SUM_W'(1) << (GUARD_BITS - 2));

    // stage 4: saturation, signs and result selection
    assign sat_a = (m_a_reg[M_W-1:FIELD_W] != '0) ? {FIELD_W{1'b1}} : m_a_reg[FIELD_W-1:0];
    assign sat_b = (m_b_reg[M_W-1:FIELD_W] != '0) ? {FIELD_W{1'b1}} : m_b_reg[FIELD_W-1:0];

    always_comb
    begin
        res_next = '0;
        if (s3_reg.cart)
        begin
            res_next.x = s3_reg.neg_a ? -{1'b0, sat_a} : {1'b0, sat_a};
            res_next.y = s3_reg.neg_b ? -{1'b0, sat_b} : {1'b0, sat_b};
        end
        else if (s3_reg.byp)
        begin
            res_next.radius = s3_reg.byp_rad;
            res_next.angle  = s3_reg.byp_ang;
        end
        else
        begin
            res_next.radius = sat_a;
            res_next.angle  = s3_reg.ang;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid)
            begin
                s1_reg    <= s1_next;
                mag_a_reg <= mag_a_next;
                mag_b_reg <= mag_b_next;
            end
            if (valid_reg[0])
            begin
                s2_reg   <= s1_reg;
                hi_a_reg <= (HI_W+INV_W)'(mag_a_reg[MAG_W-1:32]) *
                            (HI_W+INV_W)'(INV_GAIN_Q31);
                hi_b_reg <= (HI_W+INV_W)'(mag_b_reg[MAG_W-1:32]) *
                            (HI_W+INV_W)'(INV_GAIN_Q31);
                lo_a_reg <= lo_a_prod[LO_W-1:32];
                lo_b_reg <= lo_b_prod[LO_W-1:32];
            end
            if (valid_reg[1])
            begin
                s3_reg  <= s2_reg;
                m_a_reg <= sum_a[SUM_W-1:GUARD_BITS-1];
                m_b_reg <= sum_b[SUM_W-1:GUARD_BITS-1];
            end
            if (valid_reg[2])
                res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== tb/polar_cartesian_converter_tb.sv =====
// ============================================================================
// polar_cartesian_converter_tb : self-checking bench for the CORDIC converter
// Drives both conversions through the valid/stall input channel, predicts
// each result with a fixed-point CORDIC model of its own and compares every
// result transfer in order, under random idling and backpressure.
// ============================================================================
`timescale 1ns / 100ps

import pcc_pkg::*;

// expected-result tracker for the converter
class conversion_checker;

    res_t pending_results[$];
    int   mismatches;
    int   polar_items;
    int   cart_items;
    int   results_checked;

    // atan(2^-i) in units of 2^-32 turn
    bit [31:0] arc_turns [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // remove the cordic gain and the guard bits, rounding half up
    function longint unsigned remove_gain(longint unsigned mag);
        longint unsigned inv_gain;
        longint unsigned hi_part;
        longint unsigned lo_part;
        longint unsigned sum;
        inv_gain = 64'd1304065748;
        hi_part  = (mag >> 32) * inv_gain;
        lo_part  = (mag & 64'hFFFF_FFFF) * inv_gain;
        sum      = hi_part + (lo_part >> 32);
        return (sum + (64'd1 << (GUARD_BITS - 2))) >> (GUARD_BITS - 1);
    endfunction

    // signed magnitude scaling with saturation at +/-65535
    function longint scale_coord(longint v);
        longint unsigned m;
        m = remove_gain((v >= 0) ? v : -v);
        if (m > 65535)
            m = 65535;
        return (v >= 0) ? longint'(m) : -longint'(m);
    endfunction

    // vectoring mode: point to magnitude and angle
    function res_t point_to_polar(logic [15:0] x_raw, logic [15:0] y_raw);
        longint          px;
        longint          py;
        longint          a;
        longint          b;
        longint          t;
        longint unsigned r;
        bit [31:0]       z;
        bit [31:0]       z_rnd;
        res_t            res;
        res = '0;
        px  = $signed(x_raw);
        py  = $signed(y_raw);
        z   = 32'h0;
        if (px == 0 && py == 0)
            return res;
        // points on an axis take fixed angles with no rotation
        if (py == 0 || px == 0) begin
            r = (py == 0) ? ((px > 0) ? px : -px) : ((py > 0) ? py : -py);
            res.radius = (r > 65535) ? 16'hFFFF : r[15:0];
            if (py == 0)
                res.angle = (px > 0) ? ANGLE_ZERO : ANGLE_HALF;
            else
                res.angle = (py > 0) ? ANGLE_QUARTER : ANGLE_3QUART;
            return res;
        end
        // left half plane: turn by half a turn first
        if (px < 0) begin
            px = -px;
            py = -py;
            z  = 32'h80000000;
        end
        a = px * (longint'(1) << GUARD_BITS);
        b = py * (longint'(1) << GUARD_BITS);
        for (int i = 0; i < ROTATION_STEPS && i < 24; i++) begin
            t = a;
            if (b > 0) begin
                a = a + (b >>> i);
                b = b - (t >>> i);
                z = z + arc_turns[i];
            end
            else begin
                a = a - (b >>> i);
                b = b + (t >>> i);
                z = z - arc_turns[i];
            end
        end
        r = (a > 0) ? remove_gain(a) : 0;
        res.radius = (r > 65535) ? 16'hFFFF : r[15:0];
        z_rnd      = z + 32'h8000;
        res.angle  = z_rnd[31:16];
        return res;
    endfunction

    // rotation mode: radius and angle to x and y
    function res_t polar_to_point(logic [15:0] radius, logic [15:0] angle);
        longint    a;
        longint    b;
        longint    t;
        longint    resid;
        longint    xs;
        longint    ys;
        bit [31:0] z;
        bit [31:0] z_quad;
        res_t      res;
        res    = '0;
        z      = {angle, 16'h0};
        a      = longint'({48'h0, radius}) * (longint'(1) << GUARD_BITS);
        b      = 0;
        z_quad = z + 32'h40000000;
        // left half of the circle: negate and turn by half a turn
        if (z_quad[31]) begin
            a = -a;
            z = z + 32'h80000000;
        end
        resid = int'(z);
        for (int i = 0; i < ROTATION_STEPS && i < 24; i++) begin
            t = a;
            if (resid >= 0) begin
                a     = a - (b >>> i);
                b     = b + (t >>> i);
                resid = resid - longint'({32'h0, arc_turns[i]});
            end
            else begin
                a     = a + (b >>> i);
                b     = b - (t >>> i);
                resid = resid + longint'({32'h0, arc_turns[i]});
            end
        end
        xs    = scale_coord(a);
        ys    = scale_coord(b);
        res.x = xs[CART_W-1:0];
        res.y = ys[CART_W-1:0];
        return res;
    endfunction

    // accepted input transfer: queue its expected result
    function void note_input(logic cmd, logic [15:0] x, logic [15:0] y,
                             logic [15:0] radius, logic [15:0] angle);
        if (cmd == CMD_TO_POLAR) begin
            pending_results.push_back(point_to_polar(x, y));
            polar_items++;
        end
        else begin
            pending_results.push_back(polar_to_point(radius, angle));
            cart_items++;
        end
    endfunction

    // accepted result transfer: compare with the oldest expectation
    function void check_result(logic [15:0] radius, logic [15:0] angle,
                               logic [CART_W-1:0] x, logic [CART_W-1:0] y);
        res_t want;
        if (pending_results.size() == 0) begin
            $error("result transfer with no expected result pending");
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (radius !== want.radius) begin
            $error("radius_out: expected %0d, got %0d", want.radius, radius);
            mismatches++;
        end
        if (angle !== want.angle) begin
            $error("angle_out: expected %0d, got %0d", want.angle, angle);
            mismatches++;
        end
        if (x !== want.x) begin
            $error("x_out: expected %0d, got %0d", $signed(want.x), $signed(x));
            mismatches++;
        end
        if (y !== want.y) begin
            $error("y_out: expected %0d, got %0d", $signed(want.y), $signed(y));
            mismatches++;
        end
    endfunction

endclass

module polar_cartesian_converter_tb;

    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic                command;
    logic [FIELD_W-1:0]  x_in;
    logic [FIELD_W-1:0]  y_in;
    logic [FIELD_W-1:0]  radius_in;
    logic [FIELD_W-1:0]  angle_in;
    logic                result_valid;
    logic                result_stall;
    logic [FIELD_W-1:0]  radius_out;
    logic [FIELD_W-1:0]  angle_out;
    logic [CART_W-1:0]   x_out;
    logic [CART_W-1:0]   y_out;

    conversion_checker checker_q = new();

    int  items_sent;
    int  cycle_count;
    int  input_stall_cycles;
    bit  hold_done;

    polar_cartesian_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .x_in         (x_in),
        .y_in         (y_in),
        .radius_in    (radius_in),
        .angle_in     (angle_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .radius_out   (radius_out),
        .angle_out    (angle_out),
        .x_out        (x_out),
        .y_out        (y_out)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("polar_cartesian_converter_tb NOT OK");
            $finish;
        end
    end

    // result monitor and input backpressure count
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            checker_q.check_result(radius_out, angle_out, x_out, y_out);
        if (rst_n && item_valid && item_stall)
            input_stall_cycles <= input_stall_cycles + 1;
    end

    // one input transfer, with random idle cycles in front of it except for items 150 to 299
    task automatic send_item(logic cmd, logic [15:0] x, logic [15:0] y,
                             logic [15:0] radius, logic [15:0] angle);
        while (!(items_sent >= 150 && items_sent < 300) && $urandom_range(99) < 7) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        x_in       <= x;
        y_in       <= y;
        radius_in  <= radius;
        angle_in   <= angle;
        do
            @(posedge clk);
        while (item_stall);
        checker_q.note_input(cmd, x, y, radius, angle);
        items_sent++;
    endtask

    // field values weighted toward extremes, zero and small magnitudes
    function automatic logic [15:0] pick_field();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!hold_done && items_sent >= 400) begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (items_sent >= 150 && items_sent < 300)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < 7);
        end
    end

    // reset, stimulus and end of run
    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        command    <= CMD_TO_POLAR;
        x_in       <= '0;
        y_in       <= '0;
        radius_in  <= '0;
        angle_in   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // origin, axis points and the extremes of the coordinates
        send_item(CMD_TO_POLAR, 16'sd0, 16'sd0, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'sd100, 16'sd0, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, -16'sd100, 16'sd0, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'sd0, 16'sd100, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'sd0, -16'sd100, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'h8000, 16'sd0, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'sd0, 16'h8000, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'h7FFF, 16'h7FFF, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'h8000, 16'h8000, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'h8000, 16'h7FFF, 16'($urandom), 16'($urandom));
        // angle just under a full turn rounds over to zero
        send_item(CMD_TO_POLAR, 16'h7FFF, -16'sd1, 16'($urandom), 16'($urandom));
        // left half plane close to the half turn, then three unit diagonal points
        send_item(CMD_TO_POLAR, 16'h8000, -16'sd1, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, -16'sd1, 16'sd1, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, 16'sd1, -16'sd1, 16'($urandom), 16'($urandom));
        send_item(CMD_TO_POLAR, -16'sd1, -16'sd1, 16'($urandom), 16'($urandom));
        // zero, small and full-scale radius on the axes, near saturation and at quadrant edges
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd0, 16'd0);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, ANGLE_ZERO);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, ANGLE_QUARTER);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, ANGLE_HALF);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, ANGLE_3QUART);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'hFFFF, 16'd8192);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd40000, 16'd16383);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd1, 16'd24576);
        send_item(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd0, 16'd12345);

        // random part, both commands mixed
        for (int k = 0; k < RANDOM_ITEMS; k++)
            send_item(logic'($urandom_range(1)), pick_field(), pick_field(),
                      pick_field(), pick_field());
        item_valid <= 1'b0;

        // drain, then let any stray result show up
        while (checker_q.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d to-polar and %0d to-cartesian transfers, %0d results checked",
                 checker_q.polar_items, checker_q.cart_items, checker_q.results_checked);
        $display("output held off %0d cycles once; input stalled on %0d cycles",
                 HOLD_CYCLES, input_stall_cycles);
        if (checker_q.mismatches == 0)
            $display("polar_cartesian_converter_tb OK");
        else
            $display("polar_cartesian_converter_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pcc_pkg.sv
rtl/core/pcc_prep.sv
rtl/core/pcc_cell.sv
rtl/core/pcc_post.sv
rtl/core/polar_cartesian_converter.sv
tb/polar_cartesian_converter_tb.sv
